@@ hdl/ipm_ic_pkg.sv @@
// Shared types, codes and constants of the inequality condensing unit.
package ipm_ic_pkg;

	localparam int MaxVars  = 16;
	localparam int IdxW     = 4;
	localparam int FracBits = 16;

	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_SCALAR = 2'd1;
	localparam logic [1:0] REQ_JAC    = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	localparam logic [1:0] ST_READ     = 2'd0;
	localparam logic [1:0] ST_FOLDED   = 2'd1;
	localparam logic [1:0] ST_SKIPPED  = 2'd2;
	localparam logic [1:0] ST_SATURATE = 2'd3;

	localparam logic CFG_MU   = 1'b0;
	localparam logic CFG_VARS = 1'b1;

	// Saturate a 66-bit signed value to 32 bits.
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'sd2147483647) begin
			r = {1'b1, 32'h7fffffff};
		end else if (v < -66'sd2147483648) begin
			r = {1'b1, 32'h80000000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

@@ hdl/ipm_inequality_condensing_unit.sv @@
// Top level of the inequality condensing unit: model stores, row buffer and fold sequencer.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  request   | start / busy       | req_type, entry_*, *_value, jac_*, row_last
//  result    | done (one cycle)   | read_value, status
//  config    | cfg_we             | cfg_index, cfg_data
//
// Writes, row scalars and Jacobian elements that are not last do not occupy the unit.
// A read keeps the unit busy through S_RD1 and S_RD2, and its result is registered as S_RD2 ends.
// A fold runs S_NUM to form d*f, the restoring divides of lin and q in S_DIVL
// and S_DIVQ with S_LIN and S_QV after each, S_GMUL and S_TMUL per gradient
// term and S_HRD and S_HWR per Hessian term, since one shared 32x32
// multiplier does all products and the Hessian memory has one port. The result
// follows in the next cycle. A row with bad slack is reported in the cycle after
// its last element without occupying the unit. Reset clears the control state
// and the row buffer valid bits; the results cannot be stalled.
module ipm_inequality_condensing_unit import ipm_ic_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [1:0]         req_type,
	input  logic [IdxW-1:0]    entry_row,
	input  logic [IdxW-1:0]    entry_col,
	input  logic               entry_is_gradient,
	input  logic signed [31:0] entry_value,
	input  logic signed [31:0] constraint_value,
	input  logic signed [31:0] slack_value,
	input  logic signed [31:0] dual_value,
	input  logic [IdxW-1:0]    jac_column,
	input  logic signed [31:0] jac_value,
	input  logic               row_last,
	output logic signed [31:0] read_value,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [30:0]        cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD1   = 4'd1;
	localparam logic [3:0] S_RD2   = 4'd2;
	localparam logic [3:0] S_NUM   = 4'd3;
	localparam logic [3:0] S_DIVL  = 4'd4;
	localparam logic [3:0] S_LIN   = 4'd5;
	localparam logic [3:0] S_DIVQ  = 4'd6;
	localparam logic [3:0] S_QV    = 4'd7;
	localparam logic [3:0] S_GMUL  = 4'd8;
	localparam logic [3:0] S_TMUL  = 4'd9;
	localparam logic [3:0] S_HRD   = 4'd10;
	localparam logic [3:0] S_HWR   = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;

	logic [3:0]         state_q;
	logic [30:0]        mu_q;
	logic [4:0]         vars_q;
	logic signed [31:0] f_q, s_q, d_q;
	logic signed [31:0] hess_mem [MaxVars*MaxVars];
	logic signed [31:0] grad_mem [MaxVars];
	logic signed [31:0] rowbuf_q [MaxVars];
	logic [MaxVars-1:0] rowv_q;
	logic signed [31:0] t_q [MaxVars];
	logic signed [31:0] rd_q;
	logic               rsel_q;
	logic [4:0]         n_q;
	logic [IdxW-1:0]    i_q, j_q;
	logic               sat_q;
	logic signed [31:0] lin_q, qv_q;
	// shared divider: |dividend| magnitude, remainder, quotient
	logic [63:0]        dvd_q;
	logic [63:0]        quo_q;
	logic [64:0]        rem_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	// shared multiplier
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [63:0] prod_s1;
	logic [32:0]        s_res;
	logic [32:0]        t_res;
	logic               done_d;

	function automatic logic signed [31:0] rb(input logic [IdxW-1:0] k,
		input logic [MaxVars-1:0] v, input logic signed [31:0] x);
		return v[k] ? x : 32'sd0;
	endfunction

	logic signed [31:0] bi, bj;
	logic [IdxW-1:0] lo, hi;
	assign lo = (i_q < j_q) ? i_q : j_q;
	assign hi = (i_q < j_q) ? j_q : i_q;
	assign bi = rb(i_q, rowv_q, rowbuf_q[i_q]);
	assign bj = rb(hi, rowv_q, rowbuf_q[hi]);

	// The single multiplier forms d*f, then J*lin and q*J per variable, then the
	// Hessian terms.
	always_comb begin
		unique case (state_q)
			S_NUM:   begin ma = d_q; mb = f_q; end
			S_TMUL:  begin ma = qv_q; mb = bi; end
			S_HRD:   begin ma = t_q[lo]; mb = bj; end
			default: begin ma = bi; mb = lin_q; end
		endcase
	end
	assign prod = ma * mb;
	assign t_res = sat32(66'(prod >>> FracBits));

	// divisor step
	logic [64:0] rtry;
	logic [64:0] rsh;
	assign rsh  = {rem_q[63:0], dvd_q[63]};
	assign rtry = rsh - {33'd0, s_q};

	logic signed [65:0] quo_signed;
	assign quo_signed = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

	logic [32:0] lin_res, q_res;
	assign lin_res = sat32(quo_signed - 66'(d_q));
	assign q_res   = sat32(quo_signed);

	logic signed [63:0] num_l;
	assign num_l = prod - $signed({17'd0, mu_q, 16'd0});

	logic signed [63:0] num_q;
	assign num_q = 64'(d_q) <<< FracBits;

	logic signed [31:0] h_rd_s1;
	logic [2*IdxW-1:0] h_addr;
	assign h_addr = {i_q, j_q};

	logic fold_go;
	assign fold_go = start && !busy && req_type == REQ_JAC && row_last;

	logic bad_slack;
	assign bad_slack = (s_q <= 32'sd0);

	// A result leaves after a read, after a fold, or straight after a skipped row.
	assign done_d = (state_q == S_RD2) || (state_q == S_FIN) || (fold_go && bad_slack);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && req_type == REQ_WRITE && !entry_is_gradient) begin
			hess_mem[{entry_row, entry_col}] <= entry_value;
		end else if (state_q == S_HWR) begin
			hess_mem[h_addr] <= $signed(s_res[31:0]);
		end
		if (state_q == S_IDLE && start && req_type == REQ_WRITE && entry_is_gradient) begin
			grad_mem[entry_row] <= entry_value;
		end else if (state_q == S_TMUL) begin
			grad_mem[i_q] <= $signed(s_res[31:0]);
		end
		if (state_q == S_IDLE) begin
			h_rd_s1 <= hess_mem[{entry_row, entry_col}];
			rd_q    <= grad_mem[entry_row];
		end else if (state_q == S_HRD) begin
			h_rd_s1 <= hess_mem[h_addr];
		end
		prod_s1 <= prod;
		if (state_q == S_IDLE && start && req_type == REQ_JAC) begin
			rowbuf_q[jac_column] <= jac_value;
		end
		if (state_q == S_TMUL) begin
			t_q[i_q] <= $signed(t_res[31:0]);
		end
	end

	always_comb begin
		s_res = '0;
		if (state_q == S_TMUL) begin
			s_res = sat32(66'(grad_mem[i_q]) + 66'(prod_s1 >>> FracBits));
		end else begin
			s_res = sat32(66'(h_rd_s1) + 66'(prod_s1 >>> FracBits));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mu_q <= 31'd6554;
			vars_q <= 5'd16;
			f_q <= '0; s_q <= '0; d_q <= '0;
			rowv_q <= '0;
			done <= 1'b0;
			status <= ST_READ;
			read_value <= '0;
			n_q <= '0; i_q <= '0; j_q <= '0; sat_q <= 1'b0;
			lin_q <= '0; qv_q <= '0; dvd_q <= '0; quo_q <= '0; rem_q <= '0;
			neg_q <= 1'b0; cnt_q <= '0; rsel_q <= 1'b0;
		end else begin
			done <= done_d;
			if (cfg_we) begin
				if (cfg_index == CFG_MU) mu_q <= cfg_data;
				else vars_q <= cfg_data[4:0];
			end
			unique case (state_q)
				S_IDLE: if (start) begin
					unique case (req_type)
						REQ_SCALAR: begin
							f_q <= constraint_value; s_q <= slack_value; d_q <= dual_value;
						end
						REQ_JAC: begin
							if (row_last && bad_slack) begin
								status <= ST_SKIPPED; read_value <= '0;
								rowv_q <= '0;
							end else begin
								rowv_q[jac_column] <= 1'b1;
							end
							if (row_last && !bad_slack) begin
								n_q <= (vars_q > 5'(MaxVars)) ? 5'(MaxVars) : vars_q;
								sat_q <= 1'b0;
								i_q <= '0; j_q <= '0;
								state_q <= S_NUM;
							end
						end
						REQ_READ: begin
							rsel_q <= entry_is_gradient;
							state_q <= S_RD1;
						end
						default: ;
					endcase
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: begin
					status <= ST_READ;
					read_value <= rsel_q ? rd_q : h_rd_s1;
					state_q <= S_IDLE;
				end
				S_NUM: begin
					// d*f is on the multiplier this cycle.
					neg_q <= num_l[63];
					dvd_q <= num_l[63] ? -num_l : num_l;
					rem_q <= '0; quo_q <= '0; cnt_q <= '0;
					state_q <= S_DIVL;
				end
				S_DIVL, S_DIVQ: begin
					dvd_q <= {dvd_q[62:0], 1'b0};
					if (!rtry[64]) begin
						rem_q <= rtry; quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rsh; quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= (state_q == S_DIVL) ? S_LIN : S_QV;
				end
				S_LIN: begin
					lin_q <= $signed(lin_res[31:0]);
					sat_q <= sat_q | lin_res[32];
					neg_q <= d_q[31];
					dvd_q <= d_q[31] ? -num_q : num_q;
					rem_q <= '0; quo_q <= '0; cnt_q <= '0;
					state_q <= S_DIVQ;
				end
				S_QV: begin
					qv_q <= $signed(q_res[31:0]);
					sat_q <= sat_q | q_res[32];
					i_q <= '0;
					state_q <= (n_q == 5'd0) ? S_FIN : S_GMUL;
				end
				S_GMUL: state_q <= S_TMUL;
				S_TMUL: begin
					sat_q <= sat_q | t_res[32] | s_res[32];
					if (5'(i_q) + 5'd1 == n_q) begin
						i_q <= '0; j_q <= '0; state_q <= S_HRD;
					end else begin
						i_q <= i_q + 1'b1; state_q <= S_GMUL;
					end
				end
				S_HRD: state_q <= S_HWR;
				S_HWR: begin
					sat_q <= sat_q | s_res[32];
					if (5'(j_q) + 5'd1 == n_q) begin
						j_q <= '0;
						if (5'(i_q) + 5'd1 == n_q) begin
							state_q <= S_FIN;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_HRD;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_HRD;
					end
				end
				S_FIN: begin
					read_value <= '0;
					status <= sat_q ? ST_SATURATE : ST_FOLDED;
					rowv_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// S_HRD reads at h_addr into h_rd_s1 in the cycle before S_HWR uses it.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while the unit is busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_READ) |=> busy)
		else $error("read did not occupy the unit");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_READ) |-> rowv_q == '0 || status == ST_SKIPPED)
		else $error("row buffer not cleared");
	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		fold_go && s_q > 32'sd0 |=> busy)
		else $error("fold did not start");

endmodule
